[hw/rtl/tleq_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tleq_pkg
// Shared constants, request codes and structures of the two-level event queue
// arbiter.
// ----------------------------------------------------------------------------
package tleq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int EVENT_WIDTH = 16;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int RUN_W       = 8;
    localparam int REQ_W       = 2;

    localparam logic [RUN_W-1:0] LIMIT_RESET = RUN_W'(4);

    typedef enum logic [REQ_W-1:0] {
        REQ_PUSH_CRIT = 2'd0,
        REQ_PUSH_STD  = 2'd1,
        REQ_SERVE     = 2'd2,
        REQ_NOP       = 2'd3
    } t_req_type;

    typedef struct packed {
        logic push;
        logic pop;
    } t_fifo_ctl;

    typedef struct packed {
        logic [CNT_W-1:0]       count;
        logic [EVENT_WIDTH-1:0] head_data;
    } t_fifo_stat;

    typedef struct packed {
        logic                   served_valid;
        logic [EVENT_WIDTH-1:0] served_event;
        logic                   served_critical;
        logic                   push_dropped;
        logic [CNT_W-1:0]       critical_level;
        logic [CNT_W-1:0]       standard_level;
    } t_result;

endpackage
`default_nettype wire

[hw/rtl/tleq_req_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tleq_req_if
// Request channel: one beat carries a request type and an event identifier.
// ----------------------------------------------------------------------------
interface tleq_req_if;

    logic                             valid;
    logic                             ready;
    logic [tleq_pkg::REQ_W-1:0]       req_type;
    logic [tleq_pkg::EVENT_WIDTH-1:0] event_id;

    modport source (output valid, output req_type, output event_id, input ready);
    modport sink   (input valid, input req_type, input event_id, output ready);

endinterface
`default_nettype wire

[hw/rtl/tleq_res_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tleq_res_if
// Result channel: one beat per request with the served event and queue levels.
// ----------------------------------------------------------------------------
interface tleq_res_if;

    logic                             valid;
    logic                             ready;
    logic                             served_valid;
    logic [tleq_pkg::EVENT_WIDTH-1:0] served_event;
    logic                             served_critical;
    logic                             push_dropped;
    logic [tleq_pkg::CNT_W-1:0]       critical_level;
    logic [tleq_pkg::CNT_W-1:0]       standard_level;

    modport source (
        output valid, output served_valid, output served_event,
        output served_critical, output push_dropped,
        output critical_level, output standard_level,
        input  ready
    );
    modport sink (
        input  valid, input served_valid, input served_event,
        input  served_critical, input push_dropped,
        input  critical_level, input standard_level,
        output ready
    );

endinterface
`default_nettype wire

[hw/rtl/tleq_fifo.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tleq_fifo
// Circular event queue: register file with head pointer and fill count.
// ----------------------------------------------------------------------------
module tleq_fifo (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire tleq_pkg::t_fifo_ctl              i_ctl,
    input  wire logic [tleq_pkg::EVENT_WIDTH-1:0] i_data,
    output tleq_pkg::t_fifo_stat                  o_stat
);

    logic [tleq_pkg::EVENT_WIDTH-1:0] r_store [tleq_pkg::QUEUE_DEPTH];
    logic [tleq_pkg::PTR_W-1:0]       r_head;
    logic [tleq_pkg::PTR_W-1:0]       n_head;
    logic [tleq_pkg::CNT_W-1:0]       r_count;
    logic [tleq_pkg::CNT_W-1:0]       n_count;
    logic [tleq_pkg::PTR_W:0]         w_sum;
    logic [tleq_pkg::PTR_W:0]         w_tail;

    always_comb begin
        w_sum = (tleq_pkg::PTR_W + 1)'(r_head) + (tleq_pkg::PTR_W + 1)'(r_count);
        if (w_sum >= (tleq_pkg::PTR_W + 1)'(tleq_pkg::QUEUE_DEPTH)) begin
            w_tail = w_sum - (tleq_pkg::PTR_W + 1)'(tleq_pkg::QUEUE_DEPTH);
        end else begin
            w_tail = w_sum;
        end
    end

    always_comb begin
        n_head  = r_head;
        n_count = r_count;
        if (i_ctl.pop) begin
            if (r_head == tleq_pkg::PTR_W'(tleq_pkg::QUEUE_DEPTH - 1)) begin
                n_head = '0;
            end else begin
                n_head = r_head + tleq_pkg::PTR_W'(1);
            end
            n_count = r_count - tleq_pkg::CNT_W'(1);
        end else if (i_ctl.push) begin
            n_count = r_count + tleq_pkg::CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_count <= '0;
        end else begin
            r_head  <= n_head;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.push) begin
            r_store[w_tail[tleq_pkg::PTR_W-1:0]] <= i_data;
        end
    end

    assign o_stat.count     = r_count;
    assign o_stat.head_data = r_store[r_head];

endmodule
`default_nettype wire

[hw/rtl/tleq_arb.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tleq_arb
// Request decode and strict-priority arbitration with a critical run limit.
// ----------------------------------------------------------------------------
module tleq_arb (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_step,
    input  wire tleq_pkg::t_req_type           i_req_type,
    input  wire logic [tleq_pkg::RUN_W-1:0]    i_limit,
    input  wire tleq_pkg::t_fifo_stat          i_crit,
    input  wire tleq_pkg::t_fifo_stat          i_std,
    output tleq_pkg::t_fifo_ctl                o_crit_ctl,
    output tleq_pkg::t_fifo_ctl                o_std_ctl,
    output tleq_pkg::t_result                  o_res
);

    logic [tleq_pkg::RUN_W-1:0] r_run;
    logic [tleq_pkg::RUN_W-1:0] n_run;
    tleq_pkg::t_fifo_ctl        w_crit;
    tleq_pkg::t_fifo_ctl        w_std;
    logic                       w_dropped;
    logic                       w_crit_full;
    logic                       w_std_full;
    logic                       w_crit_ne;
    logic                       w_std_ne;

    assign w_crit_full = (i_crit.count == tleq_pkg::CNT_W'(tleq_pkg::QUEUE_DEPTH));
    assign w_std_full  = (i_std.count == tleq_pkg::CNT_W'(tleq_pkg::QUEUE_DEPTH));
    assign w_crit_ne   = (i_crit.count != '0);
    assign w_std_ne    = (i_std.count != '0);

    always_comb begin
        w_crit    = '0;
        w_std     = '0;
        w_dropped = 1'b0;
        n_run     = r_run;
        unique case (i_req_type)
            tleq_pkg::REQ_PUSH_CRIT: begin
                w_dropped   = w_crit_full;
                w_crit.push = !w_crit_full;
            end
            tleq_pkg::REQ_PUSH_STD: begin
                w_dropped  = w_std_full;
                w_std.push = !w_std_full;
            end
            tleq_pkg::REQ_SERVE: begin
                priority if (w_crit_ne && (r_run < i_limit)) begin
                    w_crit.pop = 1'b1;
                    n_run      = r_run + tleq_pkg::RUN_W'(1);
                end else if (w_std_ne) begin
                    w_std.pop = 1'b1;
                    n_run     = '0;
                end else begin
                    w_crit.pop = w_crit_ne;
                    n_run      = tleq_pkg::RUN_W'(w_crit_ne);
                end
            end
            tleq_pkg::REQ_NOP: begin
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        o_res.served_valid    = w_crit.pop | w_std.pop;
        o_res.served_critical = w_crit.pop;
        o_res.push_dropped    = w_dropped;
        if (w_crit.pop) begin
            o_res.served_event = i_crit.head_data;
        end else if (w_std.pop) begin
            o_res.served_event = i_std.head_data;
        end else begin
            o_res.served_event = '0;
        end
        o_res.critical_level = i_crit.count + tleq_pkg::CNT_W'(w_crit.push)
                               - tleq_pkg::CNT_W'(w_crit.pop);
        o_res.standard_level = i_std.count + tleq_pkg::CNT_W'(w_std.push)
                               - tleq_pkg::CNT_W'(w_std.pop);
    end

    assign o_crit_ctl.push = w_crit.push & i_step;
    assign o_crit_ctl.pop  = w_crit.pop & i_step;
    assign o_std_ctl.push  = w_std.push & i_step;
    assign o_std_ctl.pop   = w_std.pop & i_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= '0;
        end else if (i_step) begin
            r_run <= n_run;
        end
    end

endmodule
`default_nettype wire

[hw/rtl/two_level_event_queue_arbiter_unit.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// two_level_event_queue_arbiter_unit
// Two event queues, critical and standard, served by strict priority with a
// limit on consecutive critical serves.
// ----------------------------------------------------------------------------
// Every request beat (push critical, push standard, serve, or no operation)
// yields exactly one result beat via the input and result registers. One
// request is taken per cycle unless the result side stalls: the arbitration
// and queue update run combinationally from the input register into the
// result register, so the sustained rate is one beat per clock. While a
// result waits to be taken, the input register accepts a beat only if it is
// empty. Queue entries hold no reset value; they are only read once written.
// Write the run limit only while no request is in flight.
// ----------------------------------------------------------------------------
module two_level_event_queue_arbiter_unit (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [tleq_pkg::RUN_W-1:0]    i_cfg_wdata,
    tleq_req_if.sink                           i_req,
    tleq_res_if.source                         o_res
);

    logic                             r_in_valid;
    tleq_pkg::t_req_type              r_in_type;
    logic [tleq_pkg::EVENT_WIDTH-1:0] r_in_event;
    logic                             r_out_valid;
    tleq_pkg::t_result                r_out;
    logic [tleq_pkg::RUN_W-1:0]       r_limit;
    logic                             w_advance;
    logic                             w_step;
    tleq_pkg::t_fifo_ctl              w_crit_ctl;
    tleq_pkg::t_fifo_ctl              w_std_ctl;
    tleq_pkg::t_fifo_stat             w_crit_stat;
    tleq_pkg::t_fifo_stat             w_std_stat;
    tleq_pkg::t_result                w_res;

    assign w_advance   = !r_out_valid || o_res.ready;
    assign w_step      = r_in_valid && w_advance;
    assign i_req.ready = !r_in_valid || w_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= tleq_pkg::LIMIT_RESET;
        end else if (i_cfg_we) begin
            r_limit <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_req.ready) begin
            r_in_valid <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.ready && i_req.valid) begin
            r_in_type  <= tleq_pkg::t_req_type'(i_req.req_type);
            r_in_event <= i_req.event_id;
        end
    end

    tleq_arb u_arb (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_step     (w_step),
        .i_req_type (r_in_type),
        .i_limit    (r_limit),
        .i_crit     (w_crit_stat),
        .i_std      (w_std_stat),
        .o_crit_ctl (w_crit_ctl),
        .o_std_ctl  (w_std_ctl),
        .o_res      (w_res)
    );

    tleq_fifo u_crit_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_crit_ctl),
        .i_data  (r_in_event),
        .o_stat  (w_crit_stat)
    );

    tleq_fifo u_std_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_std_ctl),
        .i_data  (r_in_event),
        .o_stat  (w_std_stat)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_out <= w_res;
        end
    end

    assign o_res.valid           = r_out_valid;
    assign o_res.served_valid    = r_out.served_valid;
    assign o_res.served_event    = r_out.served_event;
    assign o_res.served_critical = r_out.served_critical;
    assign o_res.push_dropped    = r_out.push_dropped;
    assign o_res.critical_level  = r_out.critical_level;
    assign o_res.standard_level  = r_out.standard_level;

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !w_advance) |=> (r_in_valid && $stable(r_in_event)
                                        && $stable(r_in_type)))
        else $error("input register lost a stalled request");

    a_crit_has_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (!r_out.served_critical || r_out.served_valid))
        else $error("critical flag without a served event");

    a_level_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> ((r_out.critical_level
                          <= tleq_pkg::CNT_W'(tleq_pkg::QUEUE_DEPTH))
                         && (r_out.standard_level
                          <= tleq_pkg::CNT_W'(tleq_pkg::QUEUE_DEPTH))))
        else $error("queue level beyond depth");

    a_one_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones({w_crit_ctl.push, w_crit_ctl.pop,
                    w_std_ctl.push, w_std_ctl.pop}) <= 1)
        else $error("more than one queue operation per request");

endmodule
`default_nettype wire

[tb/tb_two_level_event_queue_arbiter_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_two_level_event_queue_arbiter_unit
// Drives random and directed requests into the two-level event queue arbiter.
// A scoreboard predicts every result beat from its own copy of both queues,
// the run counter and the run limit, and checks each beat field by field.
// Both handshake sides idle at random. The run limit is rewritten between
// phases, and the receiver holds off long enough to back up the request side.
// ----------------------------------------------------------------------------
module tb_two_level_event_queue_arbiter_unit;
    import tleq_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam int LONG_HOLD   = 80;

    class serve_predictor;
        logic [EVENT_WIDTH-1:0] crit_fifo[$];
        logic [EVENT_WIDTH-1:0] std_fifo[$];
        logic [RUN_W-1:0]       run_count;
        logic [RUN_W-1:0]       run_limit;
        t_result                expected_results[$];
        int                     errors;

        function new();
            run_count = '0;
            run_limit = LIMIT_RESET;
            errors    = 0;
        endfunction

        function void set_limit(logic [RUN_W-1:0] value);
            run_limit = value;
        endfunction

        function void note_request(logic [REQ_W-1:0] req, logic [EVENT_WIDTH-1:0] ev);
            t_result r;
            r = '0;
            case (t_req_type'(req))
                REQ_PUSH_CRIT: begin
                    if (crit_fifo.size() >= QUEUE_DEPTH) r.push_dropped = 1'b1;
                    else crit_fifo.push_back(ev);
                end
                REQ_PUSH_STD: begin
                    if (std_fifo.size() >= QUEUE_DEPTH) r.push_dropped = 1'b1;
                    else std_fifo.push_back(ev);
                end
                REQ_SERVE: begin
                    if (crit_fifo.size() != 0 && run_count < run_limit) begin
                        r.served_event    = crit_fifo.pop_front();
                        r.served_valid    = 1'b1;
                        r.served_critical = 1'b1;
                        run_count         = run_count + 1'b1;
                    end else if (std_fifo.size() != 0) begin
                        r.served_event = std_fifo.pop_front();
                        r.served_valid = 1'b1;
                        run_count      = '0;
                    end else begin
                        run_count = '0;
                        if (crit_fifo.size() != 0) begin
                            r.served_event    = crit_fifo.pop_front();
                            r.served_valid    = 1'b1;
                            r.served_critical = 1'b1;
                            run_count         = RUN_W'(1);
                        end
                    end
                end
                default: ;
            endcase
            r.critical_level = CNT_W'(crit_fifo.size());
            r.standard_level = CNT_W'(std_fifo.size());
            expected_results.push_back(r);
        endfunction

        function void compare_field(string name, int unsigned want, int unsigned got);
            if (want != got) begin
                $error("%s expected %0d actual %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_result(t_result got);
            t_result want;
            if (expected_results.size() == 0) begin
                $error("result beat with no request outstanding");
                errors++;
                return;
            end
            want = expected_results.pop_front();
            compare_field("served_valid", want.served_valid, got.served_valid);
            compare_field("served_event", want.served_event, got.served_event);
            compare_field("served_critical", want.served_critical, got.served_critical);
            compare_field("push_dropped", want.push_dropped, got.push_dropped);
            compare_field("critical_level", want.critical_level, got.critical_level);
            compare_field("standard_level", want.standard_level, got.standard_level);
        endfunction
    endclass

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             cfg_we = 1'b0;
    logic [RUN_W-1:0] cfg_wdata = LIMIT_RESET;

    tleq_req_if req_bus();
    tleq_res_if res_bus();

    two_level_event_queue_arbiter_unit DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_req       (req_bus),
        .o_res       (res_bus)
    );

    serve_predictor predictor;
    t_result        got_beat;
    bit             calm = 1'b0;
    bit             long_hold_req = 1'b0;
    int             items_sent = 0;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic int pick_gap();
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    function automatic logic [EVENT_WIDTH-1:0] rand_event();
        return EVENT_WIDTH'($urandom_range(0, 65535));
    endfunction

    task automatic send_request(input logic [REQ_W-1:0] req, input logic [EVENT_WIDTH-1:0] ev);
        int gap;
        gap = pick_gap();
        repeat (gap) begin
            @(negedge i_clk);
            req_bus.valid <= 1'b0;
        end
        @(negedge i_clk);
        req_bus.valid    <= 1'b1;
        req_bus.req_type <= req;
        req_bus.event_id <= ev;
        do @(posedge i_clk); while (!req_bus.ready);
        predictor.note_request(req, ev);
        if (req != REQ_NOP) items_sent++;
    endtask

    task automatic drain_results();
        @(negedge i_clk);
        req_bus.valid <= 1'b0;
        while (predictor.expected_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_run_limit(input logic [RUN_W-1:0] value);
        drain_results();
        @(negedge i_clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge i_clk);
        cfg_we    <= 1'b0;
        predictor.set_limit(value);
    endtask

    task automatic send_mixed(input int count);
        int pick;
        repeat (count) begin
            pick = $urandom_range(0, 9);
            if (pick < 4) send_request(REQ_PUSH_CRIT, rand_event());
            else if (pick < 6) send_request(REQ_PUSH_STD, rand_event());
            else send_request(REQ_SERVE, rand_event());
        end
    endtask

    task automatic run_random_phase(input int quota);
        int start;
        int nc;
        int ns;
        int serves;
        int r;
        start = items_sent;
        while (items_sent - start < quota) begin
            r = $urandom_range(0, 99);
            if (r < 50) begin
                nc     = $urandom_range(0, 20);
                ns     = $urandom_range(0, 20);
                serves = nc + ns + $urandom_range(0, 3);
                while (nc + ns > 0) begin
                    if (nc > 0 && (ns == 0 || $urandom_range(0, 1) == 1)) begin
                        send_request(REQ_PUSH_CRIT, rand_event());
                        nc--;
                    end else begin
                        send_request(REQ_PUSH_STD, rand_event());
                        ns--;
                    end
                end
                repeat (serves) send_request(REQ_SERVE, rand_event());
            end else if (r < 80) begin
                send_mixed($urandom_range(8, 24));
            end else begin
                repeat ($urandom_range(4, 12))
                    send_request(REQ_W'($urandom_range(0, 3)), rand_event());
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && res_bus.valid && res_bus.ready) begin
            got_beat.served_valid    = res_bus.served_valid;
            got_beat.served_event    = res_bus.served_event;
            got_beat.served_critical = res_bus.served_critical;
            got_beat.push_dropped    = res_bus.push_dropped;
            got_beat.critical_level  = res_bus.critical_level;
            got_beat.standard_level  = res_bus.standard_level;
            predictor.check_result(got_beat);
        end
    end

    initial begin
        int run;
        res_bus.ready = 1'b0;
        forever begin
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                repeat (LONG_HOLD) begin
                    @(negedge i_clk);
                    res_bus.ready <= 1'b0;
                end
            end else begin
                run = pick_gap();
                repeat (run) begin
                    @(negedge i_clk);
                    res_bus.ready <= 1'b0;
                end
                run = $urandom_range(1, 8);
                repeat (run) begin
                    @(negedge i_clk);
                    res_bus.ready <= 1'b1;
                end
            end
        end
    end

    initial begin
        int idle;
        idle = 0;
        while (idle < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((req_bus.valid && req_bus.ready) || (res_bus.valid && res_bus.ready)) idle = 0;
            else idle++;
        end
        $display("== FAIL ==");
        $finish;
    end

    initial begin
        logic [RUN_W-1:0] limits[6];
        req_bus.valid    = 1'b0;
        req_bus.req_type = REQ_NOP;
        req_bus.event_id = '0;
        predictor        = new();
        limits           = '{RUN_W'(1), RUN_W'(255), RUN_W'($urandom_range(2, 16)),
                             RUN_W'(4), RUN_W'(0), RUN_W'(3)};

        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // empty serve, no-op, extreme identifiers, strict priority with the reset limit
        send_request(REQ_SERVE, 16'hFFFF);
        send_request(REQ_NOP, 16'hFFFF);
        send_request(REQ_PUSH_CRIT, 16'hFFFF);
        send_request(REQ_PUSH_CRIT, 16'h0000);
        send_request(REQ_PUSH_CRIT, 16'h5555);
        send_request(REQ_PUSH_CRIT, 16'hAAAA);
        send_request(REQ_PUSH_CRIT, 16'h1234);
        send_request(REQ_PUSH_CRIT, 16'h8000);
        send_request(REQ_PUSH_STD, 16'h00FF);
        send_request(REQ_PUSH_STD, 16'hFF00);
        repeat (9) send_request(REQ_SERVE, 16'h0000);

        // zero limit: critical only once the standard queue is empty
        write_run_limit(RUN_W'(0));
        send_request(REQ_PUSH_CRIT, 16'h0001);
        send_request(REQ_PUSH_STD, 16'hFFFE);
        send_request(REQ_SERVE, 16'h0000);
        send_request(REQ_SERVE, 16'h0000);

        run_random_phase(20);

        foreach (limits[i]) begin
            write_run_limit(limits[i]);
            calm = (i == 2);
            if (i == 3) begin
                long_hold_req = 1'b1;
                send_mixed(30);
            end
            run_random_phase(15);
            if (i == 4) drain_results();
            run_random_phase(10);
        end
        calm = 1'b0;

        drain_results();
        repeat (6) @(posedge i_clk);
        if (predictor.errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
